// ===== rtl/core/ppst_pkg.sv =====
// ============================================================================
// Polygon point and segment test package
// Shared sizes, operation codes, answer codes and transaction structs.
// ============================================================================
package ppst_pkg;

    localparam int MaxVertices = 64;
    localparam int CoordBits   = 16;
    localparam int AddrBits    = $clog2(MaxVertices);
    localparam int CountBits   = $clog2(MaxVertices + 1);
    localparam int VertexBits  = 2 * CoordBits;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_POINT   = 2'd1,
        OP_SEGMENT = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    localparam logic [1:0] ANS_OUTSIDE  = 2'd0;
    localparam logic [1:0] ANS_INSIDE   = 2'd1;
    localparam logic [1:0] ANS_BOUNDARY = 2'd2;
    localparam logic [1:0] ANS_MEETS    = 2'd1;
    localparam logic [1:0] ANS_NONE     = 2'd0;

    typedef struct packed {
        logic [1:0]                  operation;
        logic                        new_polygon;
        logic signed [CoordBits-1:0] point_x;
        logic signed [CoordBits-1:0] point_y;
        logic signed [CoordBits-1:0] end_x;
        logic signed [CoordBits-1:0] end_y;
    } cmd_t;

    typedef struct packed {
        logic [1:0] answer;
        logic       status;
    } result_t;

endpackage

// ===== rtl/core/ppst_ram.sv =====
// ============================================================================
// Generic single-port RAM
// One write or one read per cycle; read data is registered.
// ============================================================================
module ppst_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write at the address, otherwise read it into the output register.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/core/ppst_edge_eval.sv =====
// ============================================================================
// Polygon edge evaluator
// Two-stage pipelined classification of one edge against the query.
// Stage one forms differences and products, stage two takes the decision.
// ============================================================================
module ppst_edge_eval
    import ppst_pkg::*;
(
    input  logic                         clk,
    input  logic                         in_valid,
    input  logic                         seg_mode,
    input  logic signed [CoordBits-1:0]  x0,
    input  logic signed [CoordBits-1:0]  y0,
    input  logic signed [CoordBits-1:0]  x1,
    input  logic signed [CoordBits-1:0]  y1,
    input  logic signed [CoordBits-1:0]  px,
    input  logic signed [CoordBits-1:0]  py,
    input  logic signed [CoordBits-1:0]  ex,
    input  logic signed [CoordBits-1:0]  ey,
    output logic                         out_valid,
    output logic                         crossing,
    output logic                         touching
);

    localparam int DW = CoordBits + 1;
    localparam int PW = 2 * DW + 1;

    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;

    // Edge direction and point offsets.
    diff_t ax, ay, bx, by, cx, cy, qx, qy, rx, ry;
    assign ax = diff_t'(x1) - diff_t'(x0);
    assign ay = diff_t'(y1) - diff_t'(y0);
    assign bx = diff_t'(px) - diff_t'(x0);
    assign by = diff_t'(py) - diff_t'(y0);
    assign cx = diff_t'(ex) - diff_t'(x0);
    assign cy = diff_t'(ey) - diff_t'(y0);
    // Segment direction and offsets of the edge ends from the segment start.
    assign qx = diff_t'(ex) - diff_t'(px);
    assign qy = diff_t'(ey) - diff_t'(py);
    assign rx = diff_t'(x0) - diff_t'(px);
    assign ry = diff_t'(y0) - diff_t'(py);
    diff_t sx, sy;
    assign sx = diff_t'(x1) - diff_t'(px);
    assign sy = diff_t'(y1) - diff_t'(py);

    // Stage one registers: product pairs and simple compares.
    prod_t m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg, m8_reg;
    prod_t dot_reg, len_a_reg, len_b_reg;
    logic  valid_reg, seg_reg, up_reg, down_reg, box_reg;

    logic box_x, box_y;
    always_comb
    begin
        box_x = ((x0 < x1 ? x0 : x1) <= (px > ex ? px : ex))
             && ((px < ex ? px : ex) <= (x0 > x1 ? x0 : x1));
        box_y = ((y0 < y1 ? y0 : y1) <= (py > ey ? py : ey))
             && ((py < ey ? py : ey) <= (y0 > y1 ? y0 : y1));
    end

    always_ff @(posedge clk)
    begin
        valid_reg <= in_valid;
        seg_reg   <= seg_mode;
        // Point mode: cross = ax*by - bx*ay; segment mode: edge side of ends.
        m1_reg    <= prod_t'(ax) * prod_t'(by);
        m2_reg    <= prod_t'(bx) * prod_t'(ay);
        m3_reg    <= prod_t'(ax) * prod_t'(cy);
        m4_reg    <= prod_t'(cx) * prod_t'(ay);
        m5_reg    <= prod_t'(qx) * prod_t'(ry);
        m6_reg    <= prod_t'(rx) * prod_t'(qy);
        m7_reg    <= prod_t'(qx) * prod_t'(sy);
        m8_reg    <= prod_t'(sx) * prod_t'(qy);
        dot_reg   <= prod_t'(ax) * prod_t'(bx) + prod_t'(ay) * prod_t'(by);
        len_a_reg <= prod_t'(ax) * prod_t'(ax) + prod_t'(ay) * prod_t'(ay);
        len_b_reg <= prod_t'(bx) * prod_t'(bx) + prod_t'(by) * prod_t'(by);
        up_reg    <= (y0 < py) && (py <= y1);
        down_reg  <= (y1 < py) && (py <= y0);
        box_reg   <= box_x && box_y;
    end

    // Stage two: signs and the final decision.
    prod_t cr, d1, d2, d3, d4;
    logic  s_straddle_a, s_straddle_b, ordered;
    logic  ax_bx_neg, ay_by_neg;
    assign cr = m1_reg - m2_reg;
    assign d1 = cr;
    assign d2 = m3_reg - m4_reg;
    assign d3 = m5_reg - m6_reg;
    assign d4 = m7_reg - m8_reg;

    always_comb
    begin
        s_straddle_a = !(((d1 > 0) && (d2 > 0)) || ((d1 < 0) && (d2 < 0)));
        s_straddle_b = !(((d3 > 0) && (d4 > 0)) || ((d3 < 0) && (d4 < 0)));
        // Collinear: point lies between the ends iff dot >= 0 and |b|^2 <= |a|^2.
        ordered = (dot_reg >= 0) && (len_a_reg >= len_b_reg);
        ax_bx_neg = 1'b0;
        ay_by_neg = 1'b0;
        if (seg_reg)
        begin
            crossing = 1'b0;
            touching = box_reg && s_straddle_a && s_straddle_b;
        end
        else
        begin
            priority if (cr > 0)
            begin
                crossing = up_reg;
                touching = 1'b0;
            end
            else if (cr < 0)
            begin
                crossing = down_reg;
                touching = 1'b0;
            end
            else
            begin
                crossing = 1'b0;
                touching = ordered && !ax_bx_neg && !ay_by_neg;
            end
        end
    end

    assign out_valid = valid_reg;

endmodule

// ===== rtl/core/polygon_point_and_segment_test_unit.sv =====
// ============================================================================
// Polygon point and segment test unit
// Holds one polygon in RAM and answers point and segment queries by an
// edge walk, one edge per cycle.
// ============================================================================
// Usage: drive the command struct on cmd and pulse start while busy is low;
// the transaction is taken at that edge. Exactly one result transaction
// follows on res, marked by done for one cycle; the receiver cannot stall.
// A vertex add passes through the done state to the done register. A query over
// n stored vertices reads vertex 0, then one vertex a cycle through the
// RAM's single port; after the closing edge the controller steps through the
// drain states while the two-stage edge evaluator settles, then through the
// done state. The next command may be taken at the edge that ends the done
// cycle. A query grows longer with the vertex count, set by the single RAM port
// and the edge walk; one command is in work at a time.
// Reset clears the vertex count, the controller and done; the RAM contents
// are not cleared, since only entries below the count are ever read.
// A vertex added to a full store is dropped and reported by status.
// ============================================================================
module polygon_point_and_segment_test_unit
    import ppst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FIRST = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    cmd_t                         cmd_reg;
    logic [CountBits-1:0]         count_reg, count_next;
    logic [CountBits-1:0]         idx_reg, idx_next;
    logic [1:0]                   drain_reg, drain_next;
    logic                         parity_reg, parity_next;
    logic                         hit_reg, hit_next;
    logic                         done_reg, done_next;
    result_t                      res_reg, res_next;
    logic [VertexBits-1:0]        first_reg, prev_reg;
    logic                         prev_ok_reg, prev_ok_next;

    // RAM port.
    logic                  ram_we;
    logic [AddrBits-1:0]   ram_addr;
    logic [VertexBits-1:0] ram_wdata, ram_rdata;

    ppst_ram #(.Width(VertexBits), .Depth(MaxVertices)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // Edge evaluator feeds.
    logic                  ev_valid, ev_out_valid, ev_cross, ev_touch;
    logic [VertexBits-1:0] ev_end;
    logic                  rd_valid_reg;

    ppst_edge_eval u_eval (
        .clk      (clk),
        .in_valid (ev_valid),
        .seg_mode (cmd_reg.operation == OP_SEGMENT),
        .x0       (prev_reg[VertexBits-1:CoordBits]),
        .y0       (prev_reg[CoordBits-1:0]),
        .x1       (ev_end[VertexBits-1:CoordBits]),
        .y1       (ev_end[CoordBits-1:0]),
        .px       (cmd_reg.point_x),
        .py       (cmd_reg.point_y),
        .ex       (cmd_reg.end_x),
        .ey       (cmd_reg.end_y),
        .out_valid(ev_out_valid),
        .crossing (ev_cross),
        .touching (ev_touch)
    );

    // An edge ends at the vertex just read, or at vertex 0 for the closing edge.
    always_comb
    begin
        ev_end   = (state_reg == ST_DRAIN && drain_reg == 2'd0) ? first_reg : ram_rdata;
        ev_valid = (rd_valid_reg && prev_ok_reg)
                || (state_reg == ST_DRAIN && drain_reg == 2'd0);
    end

    logic start_ok;
    assign start_ok = start && !busy;

    // Controller.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        drain_next   = drain_reg;
        parity_next  = parity_reg;
        hit_next     = hit_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        prev_ok_next = prev_ok_reg;
        ram_we       = 1'b0;
        ram_addr     = idx_reg[AddrBits-1:0];
        ram_wdata    = {cmd.point_x, cmd.point_y};
        if (ev_out_valid)
        begin
            parity_next = parity_reg ^ ev_cross;
            hit_next    = hit_reg | ev_touch;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_ok)
                begin
                    idx_next     = '0;
                    parity_next  = 1'b0;
                    hit_next     = 1'b0;
                    prev_ok_next = 1'b0;
                    drain_next   = '0;
                    unique case (cmd.operation)
                        OP_ADD:
                        begin
                            logic [CountBits-1:0] n;
                            n = cmd.new_polygon ? '0 : count_reg;
                            res_next.answer = ANS_OUTSIDE;
                            if (n < CountBits'(MaxVertices))
                            begin
                                ram_we          = 1'b1;
                                ram_addr        = n[AddrBits-1:0];
                                count_next      = n + 1'b1;
                                res_next.status = 1'b0;
                            end
                            else
                            begin
                                count_next      = n;
                                res_next.status = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        OP_POINT, OP_SEGMENT:
                        begin
                            res_next.status = 1'b0;
                            if (count_reg == '0)
                            begin
                                res_next.answer = ANS_OUTSIDE;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                ram_addr   = '0;
                                idx_next   = CountBits'(1);
                                state_next = ST_FIRST;
                            end
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FIRST, ST_WALK:
            begin
                // Issue one read a cycle until every vertex has been read.
                if (idx_reg < count_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
                if (rd_valid_reg)
                begin
                    prev_ok_next = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // Closing edge enters at the first drain step, then settle.
                if (drain_reg == 2'd3)
                begin
                    if (cmd_reg.operation == OP_POINT)
                    begin
                        res_next.answer = hit_next ? ANS_BOUNDARY
                                        : (parity_next ? ANS_INSIDE : ANS_OUTSIDE);
                    end
                    else
                    begin
                        res_next.answer = hit_next ? ANS_MEETS : ANS_NONE;
                    end
                    state_next = ST_DONE;
                end
                drain_next = drain_reg + 1'b1;
            end
            ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            drain_reg    <= '0;
            parity_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            done_reg     <= 1'b0;
            prev_ok_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            drain_reg    <= drain_next;
            parity_reg   <= parity_next;
            hit_reg      <= hit_next;
            done_reg     <= done_next;
            prev_ok_reg  <= prev_ok_next;
            rd_valid_reg <= (state_reg == ST_IDLE && state_next == ST_FIRST)
                         || ((state_reg == ST_FIRST || state_reg == ST_WALK)
                             && state_next == ST_WALK);
        end
    end

    // Payload registers: the command, the result, the first vertex and the edge start.
    always_ff @(posedge clk)
    begin
        if (start_ok)
        begin
            cmd_reg <= cmd;
        end
        res_reg <= res_next;
        if (rd_valid_reg && !prev_ok_reg)
        begin
            first_reg <= ram_rdata;
        end
        if (rd_valid_reg)
        begin
            prev_reg <= ram_rdata;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

`ifndef NO_ASSERTIONS
    // A result follows only a completed command.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DONE))
        else $error("result without a finished command");

    // The vertex count never exceeds the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountBits'(MaxVertices))
        else $error("vertex count beyond store depth");

    // The RAM is written only when a vertex add is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (start_ok && cmd.operation == OP_ADD))
        else $error("unexpected RAM write");

    // Queries never report a dropped vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && cmd_reg.operation != OP_ADD) |-> !res.status)
        else $error("status set on a query");
`endif

endmodule
